// File: hw/rtl/rlgr_pkg.sv
// Package for the run-length glyph renderer.
// Holds the request and row types, the glyph descriptor, sizes and codes.
// No dependencies.
package rlgr_pkg;

  // Fixed field widths
  localparam int POS_W   = 20;  // cursor and framebuffer offsets
  localparam int DIM_W   = 11;  // screen width and height
  localparam int GAP_W   = 6;
  localparam int COLOR_W = 16;
  localparam int GSZ_W   = 6;   // glyph width, height, y offset
  localparam int RADDR_W = 12;  // run addresses in a request
  localparam int RLEN_W  = 11;  // run lengths
  localparam int MASK_W  = 32;  // row mask

  // Parameter defaults
  localparam int GLYPH_COUNT_DEF    = 96;
  localparam int MAX_GLYPH_SIZE_DEF = 32;
  localparam int RUN_WORDS_DEF      = 4096;

  // Request kinds
  localparam logic [1:0] KIND_GLYPH = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Configuration register indexes
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LINE_GAP      = 2'd2;
  localparam logic [1:0] REG_DRAW_COLOR    = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         code;
    logic [RADDR_W-1:0] run_address;
    logic [RLEN_W-1:0]  run_length;
    logic [GSZ_W-1:0]   glyph_width;
    logic [GSZ_W-1:0]   glyph_height;
    logic [GSZ_W-1:0]   glyph_y_offset;
    logic [RADDR_W-1:0] run_start;
    logic [RADDR_W-1:0] run_end;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]   row_address;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               row_last;
  } row_t;

  typedef struct packed {
    logic [GSZ_W-1:0]   w;
    logic [GSZ_W-1:0]   h;
    logic [GSZ_W-1:0]   yoff;
    logic [RADDR_W-1:0] first;
    logic [RADDR_W-1:0] stop;
  } glyph_desc_t;

endpackage

// File: hw/rtl/rlgr_div.sv
// Restoring divider: cursor divided by the screen width, one bit a cycle.
// Gives the row (quotient) and column (remainder). Uses rlgr_pkg.
module rlgr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rlgr_pkg::POS_W-1:0] dividend,
  input  logic [rlgr_pkg::DIM_W-1:0] divisor,
  output logic                      busy,
  output logic [rlgr_pkg::POS_W-1:0] quotient,
  output logic [rlgr_pkg::DIM_W-1:0] remainder
);
  import rlgr_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] quo;
  logic [DIM_W-1:0] rem;
  logic [DIM_W-1:0] dsr;
  logic [DIM_W:0]   sh;
  logic [DIM_W:0]   diff;
  logic             ge;

  // One trial subtraction per cycle
  always_comb begin
    sh   = {rem, quo[POS_W-1]};
    ge   = sh >= {1'b0, dsr};
    diff = sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(POS_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[POS_W-2:0], ge};
      rem <= ge ? diff[DIM_W-1:0] : sh[DIM_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: hw/rtl/rlgr_glyph_mem.sv
// Glyph descriptor table: synchronous memory with per-entry valid bits.
// An entry never loaded reads as an empty glyph. Uses rlgr_pkg.
module rlgr_glyph_mem #(
  parameter int GLYPH_COUNT = rlgr_pkg::GLYPH_COUNT_DEF,
  parameter int IDX_W       = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  rlgr_pkg::glyph_desc_t     wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_idx,
  output rlgr_pkg::glyph_desc_t     rd_data
);
  import rlgr_pkg::*;

  glyph_desc_t            mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] valid;
  glyph_desc_t            data_q;
  logic                   valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_idx];
    end
  end

  // Valid bits stand in for the all-zero reset of the table
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        valid_q <= valid[rd_idx];
      end
    end
  end

  assign rd_data = valid_q ? data_q : '0;

endmodule

// File: hw/rtl/rlgr_run_mem.sv
// Run length memory: one write port, one registered read port.
// Contents are undefined until written. Uses rlgr_pkg.
module rlgr_run_mem #(
  parameter int RUN_WORDS = rlgr_pkg::RUN_WORDS_DEF,
  parameter int ADDR_W    = 12
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [rlgr_pkg::RLEN_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [rlgr_pkg::RLEN_W-1:0] rd_data
);
  import rlgr_pkg::*;

  logic [RLEN_W-1:0] mem [RUN_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/run_length_glyph_renderer.sv
// Channel | Dir | Handshake             | Payload
// cmd     | in  | cmd_valid/cmd_ready   | rlgr_pkg::cmd_t (load glyph, load run, draw)
// row     | out | row_valid/row_ready   | rlgr_pkg::row_t (one glyph row)
// cfg     | in  | cfg_write             | cfg_index, cfg_data
//
// Loads are written straight from the idle state. A control character waits for
// the 20-step cursor/width divider. A glyph reads its runs one at a time through
// the single run memory read port and builds one row segment per cycle while
// filling.
// Synchronous reset clears the cursor and glyph valid bits, sets register defaults.
// A stalled row holds the sequencer; requests wait until the draw finishes.
// Depends on rlgr_pkg, rlgr_div, rlgr_glyph_mem, rlgr_run_mem.
module run_length_glyph_renderer #(
  parameter int GLYPH_COUNT    = rlgr_pkg::GLYPH_COUNT_DEF,
  parameter int MAX_GLYPH_SIZE = rlgr_pkg::MAX_GLYPH_SIZE_DEF,
  parameter int RUN_WORDS      = rlgr_pkg::RUN_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  rlgr_pkg::cmd_t               cmd,
  output logic                         row_valid,
  input  logic                         row_ready,
  output rlgr_pkg::row_t               row,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rlgr_pkg::COLOR_W-1:0] cfg_data
);
  import rlgr_pkg::*;

  localparam int GI_W       = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int RA_W       = (RUN_WORDS > 1) ? $clog2(RUN_WORDS) : 1;
  localparam int SIZE_LIMIT = (MAX_GLYPH_SIZE < MASK_W) ? MAX_GLYPH_SIZE : MASK_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOK  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_WRAP  = 9'b000001000,
    S_PLACE = 9'b000010000,
    S_RDRUN = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_FILL  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // Configuration and cursor
  logic [DIM_W-1:0]   screen_width;
  logic [DIM_W-1:0]   screen_height;
  logic [GAP_W-1:0]   line_gap;
  logic [COLOR_W-1:0] draw_color;
  logic [POS_W-1:0]   cursor;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;

  assign w_eff = (screen_width == '0) ? DIM_W'(1) : screen_width;
  assign h_eff = (screen_height == '0) ? DIM_W'(1) : screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(320);
      screen_height <= DIM_W'(240);
      line_gap      <= '0;
      draw_color    <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[DIM_W-1:0];
        REG_LINE_GAP:      line_gap      <= cfg_data[GAP_W-1:0];
        REG_DRAW_COLOR:    draw_color    <= cfg_data;
      endcase
    end
  end

  // Request decode
  logic            cmd_fire;
  logic [7:0]      code_off;
  logic            code_in_range;
  logic [GI_W-1:0] glyph_idx;
  logic            run_wr;
  glyph_desc_t     load_desc;

  assign cmd_ready     = (state == S_IDLE);
  assign cmd_fire      = cmd_valid && cmd_ready;
  assign code_off      = cmd.code - CH_SPACE;
  assign code_in_range = (cmd.code >= CH_SPACE) && (32'(code_off) < GLYPH_COUNT);
  assign glyph_idx     = code_in_range ? code_off[GI_W-1:0] : '0;
  assign run_wr        = cmd_fire && (cmd.kind == KIND_RUN) &&
                         (32'(cmd.run_address) < RUN_WORDS);

  always_comb begin
    load_desc.w     = cmd.glyph_width;
    load_desc.h     = cmd.glyph_height;
    load_desc.yoff  = cmd.glyph_y_offset;
    load_desc.first = cmd.run_start;
    load_desc.stop  = cmd.run_end;
  end

  // Glyph table
  glyph_desc_t g_rd;
  logic        draw_fire;

  assign draw_fire = cmd_fire && (cmd.kind == KIND_DRAW);

  rlgr_glyph_mem #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .IDX_W       (GI_W)
  ) u_glyph_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_fire && (cmd.kind == KIND_GLYPH) && code_in_range),
    .wr_idx  (glyph_idx),
    .wr_data (load_desc),
    .rd_en   (draw_fire),
    .rd_idx  (glyph_idx),
    .rd_data (g_rd)
  );

  // Run memory
  glyph_desc_t        desc;
  logic [RADDR_W-1:0] j;
  logic [RLEN_W-1:0]  run_rd;
  logic               run_rd_en;
  logic               run_ok;

  assign run_rd_en = (state == S_RDRUN) && (j < desc.stop);

  rlgr_run_mem #(
    .RUN_WORDS (RUN_WORDS),
    .ADDR_W    (RA_W)
  ) u_run_mem (
    .clk     (clk),
    .wr_en   (run_wr),
    .wr_addr (RA_W'(cmd.run_address)),
    .wr_data (cmd.run_length),
    .rd_en   (run_rd_en),
    .rd_addr (RA_W'(j)),
    .rd_data (run_rd)
  );

  // Cursor / width divider
  logic             div_busy;
  logic [POS_W-1:0] div_q;
  logic [DIM_W-1:0] div_r;

  rlgr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (draw_fire),
    .dividend  (cursor),
    .divisor   (w_eff),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Draw working registers
  logic [7:0]         code_q;
  logic               glyph_ok;
  logic [11:0]        area;
  logic [21:0]        screen_px;
  logic [16:0]        gap_px;
  logic [16:0]        yoff_px;
  logic [POS_W:0]     pos;
  logic [POS_W:0]     line;
  logic [POS_W-1:0]   addr;
  logic [GSZ_W-1:0]   r;
  logic [GSZ_W-1:0]   c;
  logic [RLEN_W-1:0]  len;
  logic               parity;
  logic               runs_done;
  logic [MASK_W-1:0]  mask;

  // Glyph rejection and wrap decisions
  logic              unusable;
  logic              wrap_line;
  logic [POS_W:0]    next_line_pos;
  logic [POS_W:0]    place_pos;

  always_comb begin
    unusable = (desc.w == '0) || (desc.h == '0) ||
               (32'(desc.w) > SIZE_LIMIT) || (32'(desc.h) > SIZE_LIMIT) ||
               ({10'b0, area} >= screen_px);
    wrap_line     = (12'(div_r) + 12'(desc.w)) > 12'(w_eff);
    next_line_pos = 21'(cursor) + 21'(w_eff - div_r) + 21'(gap_px);
    place_pos     = ((22'(line) + 22'(desc.h)) > 22'(h_eff)) ? '0 : pos;
  end

  // Row segment for the current run
  logic [GSZ_W-1:0]  avail;
  logic [GSZ_W-1:0]  seg_n;
  logic [MASK_W-1:0] seg;
  logic              row_free;
  logic              last_row;

  always_comb begin
    avail    = desc.w - c;
    seg_n    = (len < RLEN_W'(avail)) ? len[GSZ_W-1:0] : avail;
    seg      = MASK_W'((33'd1 << seg_n) - 33'd1) << c;
    row_free = !row_valid || row_ready;
    last_row = (GSZ_W'(r + 1'b1) == desc.h);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cursor <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (draw_fire) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            priority if (code_q == CH_SPACE) begin
              cursor <= cursor + POS_W'(desc.w);
              state  <= S_IDLE;
            end else if (code_q == CH_TAB) begin
              cursor <= cursor + POS_W'({desc.w, 2'b00});
              state  <= S_IDLE;
            end else if (code_q == CH_LF) begin
              cursor <= next_line_pos[POS_W-1:0];
              state  <= S_IDLE;
            end else if (code_q == CH_CR) begin
              cursor <= cursor - POS_W'(div_r);
              state  <= S_IDLE;
            end else if (!glyph_ok || unusable) begin
              state <= S_IDLE;
            end else begin
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          state <= S_PLACE;
        end
        S_PLACE: begin
          cursor <= POS_W'(place_pos + 21'(desc.w));
          state  <= S_RDRUN;
        end
        S_RDRUN: begin
          state <= run_rd_en ? S_WAIT : S_EMIT;
        end
        S_WAIT: begin
          state <= S_FILL;
        end
        S_FILL: begin
          if (len == '0) begin
            state <= S_RDRUN;
          end else if (GSZ_W'(c + seg_n) == desc.w) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (row_free) begin
            if (last_row) begin
              state <= S_IDLE;
            end else if (!runs_done) begin
              state <= S_FILL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the draw
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        code_q   <= cmd.code;
        glyph_ok <= code_in_range;
      end
      S_LOOK: begin
        desc      <= g_rd;
        area      <= 12'(g_rd.w) * 12'(g_rd.h);
        screen_px <= 22'(w_eff) * 22'(h_eff);
        gap_px    <= 17'(w_eff) * 17'(line_gap);
        yoff_px   <= 17'(w_eff) * 17'(g_rd.yoff);
      end
      S_DIV: begin
      end
      S_WRAP: begin
        if (wrap_line) begin
          pos  <= next_line_pos;
          line <= 21'(div_q) + 21'(1) + 21'(line_gap);
        end else begin
          pos  <= 21'(cursor);
          line <= 21'(div_q);
        end
      end
      S_PLACE: begin
        addr      <= POS_W'(place_pos + 21'(yoff_px));
        j         <= desc.first;
        parity    <= 1'b0;
        r         <= '0;
        c         <= '0;
        mask      <= '0;
        runs_done <= 1'b0;
      end
      S_RDRUN: begin
        run_ok <= 32'(j) < RUN_WORDS;
        if (!run_rd_en) begin
          runs_done <= 1'b1;
        end
      end
      S_WAIT: begin
        len <= run_ok ? run_rd : '0;
      end
      S_FILL: begin
        if (len == '0) begin
          j      <= j + 1'b1;
          parity <= ~parity;
        end else begin
          if (parity) begin
            mask <= mask | seg;
          end
          c   <= c + seg_n;
          len <= len - RLEN_W'(seg_n);
        end
      end
      S_EMIT: begin
        if (row_free) begin
          addr <= addr + POS_W'(w_eff);
          r    <= r + 1'b1;
          c    <= '0;
          mask <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if ((state == S_EMIT) && row_free) begin
      row_valid <= 1'b1;
    end else if (row_ready) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && row_free) begin
      row.row_address <= addr;
      row.row_mask    <= mask;
      row.pixel_color <= draw_color;
      row.row_last    <= last_row;
    end
  end

endmodule

// File: hw/rtl/rlgr_checker.sv
// Port-level checks for the run-length glyph renderer, bound to the top level.
// Depends on rlgr_pkg and run_length_glyph_renderer.
module rlgr_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input rlgr_pkg::cmd_t cmd,
  input logic           row_valid,
  input logic           row_ready,
  input rlgr_pkg::row_t row
);
  import rlgr_pkg::*;

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk) rst |=> !row_valid)
    else $error("row_valid high after reset");

  // A stalled row holds
  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_ready |=> row_valid && $stable(row))
    else $error("stalled row changed");

  // A row that is not the last one means the draw is still running
  a_busy_mid_glyph: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row.row_last |-> !cmd_ready)
    else $error("request taken while a glyph is still being drawn");

  // A draw request always keeps the block busy for the next cycle
  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.kind == KIND_DRAW) |=> !cmd_ready)
    else $error("ready right after a draw request");

endmodule

bind run_length_glyph_renderer rlgr_checker u_rlgr_checker (.*);

// File: verif/run_length_glyph_renderer_chk.sv
// Checker for the run-length glyph renderer: watches the request, row and
// register ports, predicts the rows of every draw and compares them in order.
// Depends on rlgr_pkg.
module run_length_glyph_renderer_chk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_ready,
  input  rlgr_pkg::cmd_t               cmd,
  input  logic                         row_valid,
  input  logic                         row_ready,
  input  rlgr_pkg::row_t               row,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rlgr_pkg::COLOR_W-1:0] cfg_data,
  output int                           errors,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlgr_pkg::*;

  localparam int GLYPHS = GLYPH_COUNT_DEF;
  localparam int RUNS   = RUN_WORDS_DEF;
  localparam int SIZE_MAX = (MAX_GLYPH_SIZE_DEF < 32) ? MAX_GLYPH_SIZE_DEF : 32;
  localparam longint POS_MOD = 64'h100000;

  // Shadow state of the block
  logic [DIM_W-1:0]   scr_w, scr_h;
  logic [GAP_W-1:0]   gap;
  logic [COLOR_W-1:0] color;
  logic [POS_W-1:0]   cur;
  glyph_desc_t        glyphs [GLYPHS];
  logic [RLEN_W-1:0]  run_words [RUNS];
  row_t               expected_rows [$];

  assign pending = expected_rows.size();

  // Apply one accepted request to the shadow state, queue any rows it draws
  task automatic render_request(input cmd_t c);
    longint wd, ht, col, pos, base, total, p, len, stop_p;
    glyph_desc_t g;
    logic [31:0] masks [32];
    row_t r;
    int j;
    wd = (scr_w == 0) ? 1 : scr_w;
    ht = (scr_h == 0) ? 1 : scr_h;
    if (c.kind == KIND_GLYPH) begin
      if (c.code >= CH_SPACE && c.code - CH_SPACE < GLYPHS)
        glyphs[c.code - CH_SPACE] = '{c.glyph_width, c.glyph_height, c.glyph_y_offset,
                                      c.run_start, c.run_end};
      return;
    end
    if (c.kind == KIND_RUN) begin
      run_words[c.run_address] = c.run_length;
      return;
    end
    if (c.kind != KIND_DRAW) return;
    col = cur % wd;
    // Controls come before the glyph checks; space and tab step by the width of glyph 0
    if (c.code == CH_SPACE) begin
      cur = POS_W'((cur + glyphs[0].w) % POS_MOD);
      return;
    end
    if (c.code == CH_TAB) begin
      cur = POS_W'((cur + 4 * glyphs[0].w) % POS_MOD);
      return;
    end
    if (c.code == CH_LF) begin
      cur = POS_W'((cur + (wd - col) + wd * gap) % POS_MOD);
      return;
    end
    if (c.code == CH_CR) begin
      cur = POS_W'((cur - col) % POS_MOD);
      return;
    end
    if (c.code < CH_SPACE || c.code - CH_SPACE >= GLYPHS) return;
    g = glyphs[c.code - CH_SPACE];
    if (g.w == 0 || g.h == 0 || g.w > SIZE_MAX || g.h > SIZE_MAX) return;
    if (longint'(g.w) * g.h >= wd * ht) return;
    // Wrap right edge, then bottom
    pos = cur;
    if (pos % wd + g.w > wd) pos += (wd - pos % wd) + wd * gap;
    if (pos / wd + g.h > ht) pos = 0;
    cur = POS_W'((pos + g.w) % POS_MOD);
    base = pos + longint'(g.yoff) * wd;
    // Alternating skip/draw runs, row-major
    for (int k = 0; k < 32; k++) masks[k] = '0;
    total = longint'(g.w) * g.h;
    p = 0;
    for (j = g.first; j < g.stop && p < total; j++) begin
      len = run_words[j];
      stop_p = (p + len < total) ? p + len : total;
      if ((j - g.first) & 1)
        for (longint q = p; q < stop_p; q++) masks[q / g.w][q % g.w] = 1'b1;
      p = stop_p;
    end
    for (int k = 0; k < g.h; k++) begin
      r.row_address = POS_W'((base + k * wd) % POS_MOD);
      r.row_mask    = masks[k];
      r.pixel_color = color;
      r.row_last    = (k + 1 == g.h);
      expected_rows.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scr_w  = DIM_W'(320);
      scr_h  = DIM_W'(240);
      gap    = '0;
      color  = 16'hFFFF;
      cur    = '0;
      errors = 0;
      foreach (glyphs[i]) glyphs[i] = '0;
      foreach (run_words[i]) run_words[i] = '0;
      expected_rows.delete();
    end else begin
      // Register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  scr_w = cfg_data[DIM_W-1:0];
          REG_SCREEN_HEIGHT: scr_h = cfg_data[DIM_W-1:0];
          REG_LINE_GAP:      gap   = cfg_data[GAP_W-1:0];
          REG_DRAW_COLOR:    color = cfg_data;
        endcase
      end
      if (cmd_valid && cmd_ready) render_request(cmd);
      // Compare rows against oldest prediction
      if (row_valid && row_ready) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row: address %0h mask %0h", row.row_address, row.row_mask);
          errors++;
        end else begin
          row_t e;
          e = expected_rows.pop_front();
          if (row.row_address !== e.row_address) begin
            $error("row_address expected %0h actual %0h", e.row_address, row.row_address);
            errors++;
          end
          if (row.row_mask !== e.row_mask) begin
            $error("row_mask expected %0h actual %0h", e.row_mask, row.row_mask);
            errors++;
          end
          if (row.pixel_color !== e.pixel_color) begin
            $error("pixel_color expected %0h actual %0h", e.pixel_color, row.pixel_color);
            errors++;
          end
          if (row.row_last !== e.row_last) begin
            $error("row_last expected %0b actual %0b", e.row_last, row.row_last);
            errors++;
          end
        end
      end
    end
  end
endmodule

// File: verif/run_length_glyph_renderer_tb.sv
// Top of the run-length glyph renderer testbench: clock, reset, request and
// register stimulus, row back-pressure and the verdict.
// Depends on rlgr_pkg, run_length_glyph_renderer, run_length_glyph_renderer_chk.
module run_length_glyph_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlgr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;

  logic clk, rst;
  logic cmd_valid, cmd_ready, row_valid, row_ready, cfg_write;
  logic [1:0] cfg_index;
  logic [COLOR_W-1:0] cfg_data;
  cmd_t cmd;
  row_t row;
  int errors, pending, cycles, sent, idle_pct, stall_pct;
  bit run_written [RUN_WORDS_DEF];

  run_length_glyph_renderer uut (.*);
  run_length_glyph_renderer_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Row back-pressure
  initial begin
    row_ready = 0;
    forever @(negedge clk) row_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Present one request, with random sender gaps, and wait for acceptance
  task automatic send(input cmd_t c);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    if (c.kind == KIND_RUN) run_written[c.run_address] = 1;
    sent++;
  endtask

  function automatic cmd_t make_req(input logic [1:0] kind, input logic [7:0] code);
    cmd_t c;
    c = '0;
    c.kind = kind;
    c.code = code;
    return c;
  endfunction

  task automatic load_run(input int addr, input int len);
    cmd_t c;
    c = make_req(KIND_RUN, 8'h00);
    c.run_address = RADDR_W'(addr);
    c.run_length = RLEN_W'(len);
    send(c);
  endtask

  task automatic load_glyph(input logic [7:0] code, input int w, input int h,
                            input int yoff, input int first, input int stop);
    cmd_t c;
    c = make_req(KIND_GLYPH, code);
    c.glyph_width = GSZ_W'(w);
    c.glyph_height = GSZ_W'(h);
    c.glyph_y_offset = GSZ_W'(yoff);
    c.run_start = RADDR_W'(first);
    c.run_end = RADDR_W'(stop);
    send(c);
  endtask

  // Settle, then write the four registers
  task automatic set_regs(input int w, input int h, input int g, input int col);
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1; cfg_index <= REG_SCREEN_WIDTH;  cfg_data <= COLOR_W'(w);
    @(negedge clk);
    cfg_index <= REG_SCREEN_HEIGHT; cfg_data <= COLOR_W'(h);
    @(negedge clk);
    cfg_index <= REG_LINE_GAP;      cfg_data <= COLOR_W'(g);
    @(negedge clk);
    cfg_index <= REG_DRAW_COLOR;    cfg_data <= COLOR_W'(col);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  // Random traffic: mostly written runs + glyph + draws, rest noise
  task automatic random_traffic(input int count);
    cmd_t c;
    int first, nruns, w, h, stop_at;
    logic [7:0] code;
    stop_at = sent + count;
    while (sent < stop_at) begin
      if ($urandom_range(0, 99) < 70) begin
        nruns = $urandom_range(0, 10);
        first = $urandom_range(0, RUN_WORDS_DEF - 1 - nruns);
        for (int k = 0; k < nruns; k++)
          if (!run_written[first + k] || $urandom_range(0, 1))
            load_run(first + k, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, 12));
        code = CH_SPACE + 8'($urandom_range(0, GLYPH_COUNT_DEF - 1));
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
        h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
        load_glyph(code, w, h, $urandom_range(0, 63), first, first + nruns);
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 7))
            0: send(make_req(KIND_DRAW, CH_LF));
            1: send(make_req(KIND_DRAW, CH_CR));
            2: send(make_req(KIND_DRAW, CH_TAB));
            3: send(make_req(KIND_DRAW, CH_SPACE));
            default: send(make_req(KIND_DRAW, code));
          endcase
        end
      end else begin
        c = cmd_t'({$urandom, $urandom, $urandom});
        // glyph noise never points at unwritten runs
        if (c.kind == KIND_GLYPH) c.run_end = RADDR_W'($urandom_range(0, c.run_start));
        send(c);
      end
    end
  endtask

  initial begin
    cmd_valid = 0;
    cmd = '0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: runs, edge glyphs, every control, codes without glyph
    load_run(0, 0);
    load_run(1, 3);
    load_run(2, 2047);
    load_run(3, 1);
    load_run(4, 5);
    load_run(5, 2);
    load_run(4095, 0);
    load_glyph(CH_SPACE, 4, 6, 0, 0, 6);
    load_glyph(8'h41, 32, 32, 63, 0, 6);
    load_glyph(8'h7F, 1, 1, 2, 5, 3);      // no runs
    load_glyph(8'h42, 33, 4, 0, 0, 2);     // oversized
    load_glyph(8'h43, 0, 4, 0, 0, 2);      // zero width
    load_glyph(8'h80, 4, 4, 0, 0, 2);      // beyond table, ignored
    load_glyph(8'h10, 4, 4, 0, 0, 2);      // below table, ignored
    send(make_req(KIND_DRAW, 8'h41));
    send(make_req(KIND_DRAW, CH_SPACE));
    send(make_req(KIND_DRAW, CH_TAB));
    send(make_req(KIND_DRAW, CH_LF));
    send(make_req(KIND_DRAW, CH_CR));
    send(make_req(KIND_DRAW, 8'h7F));
    send(make_req(KIND_DRAW, 8'h42));
    send(make_req(KIND_DRAW, 8'h43));
    send(make_req(KIND_DRAW, 8'h80));
    send(make_req(KIND_DRAW, 8'h05));
    send(make_req(2'd3, 8'h41));

    // Phases: register settings crossed with idling modes
    random_traffic(60);
    set_regs(40, 30, 3, 16'h1234);
    idle_pct = 47; stall_pct = 0;
    random_traffic(70);
    set_regs(1024, 1024, 63, 16'h0000);
    idle_pct = 0; stall_pct = 47;
    random_traffic(60);
    set_regs(1, 1, 0, 16'hFFFF);
    idle_pct = 29; stall_pct = 29;
    random_traffic(20);
    set_regs(0, 512, 7, $urandom_range(0, 65535));
    random_traffic(20);
    set_regs(24, 20, 1, 16'hA5A5);
    idle_pct = 0; stall_pct = 0;
    random_traffic(50);

    // Drain
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
